// ===== design/cmb_pkg.sv =====
// ----------------------------------------------------------------------------
// cmb_pkg
// Shared types and constants for the coverage accumulate / mask / blend unit.
// ----------------------------------------------------------------------------
package cmb_pkg;

  localparam logic [31:0] ROW_START_COVERAGE = 32'd131072;
  localparam logic [9:0]  MASK_LIMIT         = 10'd512;
  localparam logic [31:0] RULED_SPAN         = 32'd1024;
  localparam logic [7:0]  MASK_OPAQUE        = 8'hFF;
  localparam logic [7:0]  MASK_NONE          = 8'h00;

  // Register indexes on the configuration port (byte address 4*index)
  typedef enum logic [1:0] {
    REG_FILL_MODE      = 2'd0,
    REG_SOURCE_COLOR   = 2'd1,
    REG_GLOBAL_ALPHA   = 2'd2,
    REG_FILL_RULE_MASK = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        fill_mode;
    logic [31:0] source_color;
    logic [7:0]  global_alpha;
    logic [31:0] fill_rule_mask;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] cell_delta;
    logic        [31:0] dst_pixel;
    logic               row_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic        write_enable;
    logic [7:0]  mask_value;
  } out_item_t;

  // Entry passed from the front part to the back part
  typedef struct packed {
    logic [9:0]  coverage_mag;
    logic [31:0] dst_pixel;
    logic        box;
  } qent_t;

endpackage

// ===== design/coverage_accumulate_mask_blend_unit.sv =====
// ----------------------------------------------------------------------------
// coverage_accumulate_mask_blend_unit
// Solid-color fill pixel unit with analytic coverage accumulation.
// ----------------------------------------------------------------------------
// Takes one pixel item per cycle while pixel_stall is low and gives one result
// per pixel, in order. A pixel passes through the coverage stage, the queue,
// the mask register and the output register. The running coverage adder is
// the only feedback, so the sustained rate is one pixel per clock when nothing
// stalls. The queue of QUEUE_DEPTH entries between the coverage front and the
// blend back lets the pixel side keep streaming while a stalled result holds.
// Configuration is to be written through the APB port only while no pixel is
// in flight; the user is bound to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module coverage_accumulate_mask_blend_unit
  import cmb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  in_item_t    pixel,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  logic  push;
  qent_t push_data;
  logic  q_full;
  logic  pop;
  qent_t q_data;
  logic  q_nonempty;

  cmb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cmb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  cmb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .nonempty  (q_nonempty)
  );

  cmb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_nonempty   (q_nonempty),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== design/cmb_cfg.sv =====
// ----------------------------------------------------------------------------
// cmb_cfg
// APB register file holding fill mode, source color, global alpha and rule mask.
// ----------------------------------------------------------------------------
module cmb_cfg
  import cmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_mode      <= 1'b1;
      cfg.source_color   <= 32'h0000_0000;
      cfg.global_alpha   <= 8'hFF;
      cfg.fill_rule_mask <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FILL_MODE:      cfg.fill_mode      <= pwdata[0];
        REG_SOURCE_COLOR:   cfg.source_color   <= pwdata;
        REG_GLOBAL_ALPHA:   cfg.global_alpha   <= pwdata[7:0];
        REG_FILL_RULE_MASK: cfg.fill_rule_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILL_MODE:      prdata = {31'd0, cfg.fill_mode};
      REG_SOURCE_COLOR:   prdata = cfg.source_color;
      REG_GLOBAL_ALPHA:   prdata = {24'd0, cfg.global_alpha};
      REG_FILL_RULE_MASK: prdata = cfg.fill_rule_mask;
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/cmb_front.sv =====
// ----------------------------------------------------------------------------
// cmb_front
// Accepts pixel items, updates the running coverage and forms the clamped
// coverage magnitude that the back part turns into a mask.
// ----------------------------------------------------------------------------
module cmb_front
  import cmb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     pixel_valid,
  output logic     pixel_stall,
  input  in_item_t pixel,
  output logic     push,
  output qent_t    push_data,
  input  logic     q_full
);

  logic        s1_valid;
  logic [31:0] s1_dst;
  logic        s1_box;
  logic [31:0] running_coverage;
  logic [31:0] running_coverage_next;
  logic        accept;
  logic [31:0] shifted;
  logic [31:0] ruled;
  logic [11:0] centered;
  logic [9:0]  mag;

  assign pixel_stall = s1_valid && q_full;
  assign accept      = pixel_valid && !pixel_stall;
  assign push        = s1_valid && !q_full;

  assign running_coverage_next =
      (pixel.row_start ? ROW_START_COVERAGE : running_coverage) + 32'(pixel.cell_delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      running_coverage <= ROW_START_COVERAGE;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
      // box fill leaves the coverage untouched
      if (accept && cfg.fill_mode) begin
        running_coverage <= running_coverage_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dst <= pixel.dst_pixel;
      s1_box <= !cfg.fill_mode;
    end
  end

  // |ruled - 512| clamped to 512; only ruled in 1..1023 stays below the clamp
  always_comb begin
    shifted  = 32'($signed(running_coverage) >>> 8);
    ruled    = shifted & cfg.fill_rule_mask;
    centered = {1'b0, ruled[10:0]} - {2'b00, MASK_LIMIT};
    if (ruled <= RULED_SPAN) begin
      mag = centered[11] ? 10'(12'd0 - centered) : centered[9:0];
    end else begin
      mag = MASK_LIMIT;
    end
  end

  assign push_data.coverage_mag = mag;
  assign push_data.dst_pixel    = s1_dst;
  assign push_data.box          = s1_box;

endmodule

// ===== design/cmb_queue.sv =====
// ----------------------------------------------------------------------------
// cmb_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module cmb_queue
  import cmb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t pop_data,
  output logic  nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  qent_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/cmb_back.sv =====
// ----------------------------------------------------------------------------
// cmb_back
// Forms the 8-bit mask, blends the source color over the destination pixel
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module cmb_back
  import cmb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_nonempty,
  input  qent_t     q_data,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic        m_valid;
  logic [7:0]  m_mask;
  logic [31:0] m_dst;
  logic        m_box;
  logic        m_ready;
  logic        o_ready;
  logic        m_advance;
  logic [17:0] scaled;
  logic [7:0]  mask_calc;
  logic [31:0] blended;
  out_item_t   result_next;

  assign o_ready   = !result_valid || !result_stall;
  assign m_advance = m_valid && o_ready;
  assign m_ready   = !m_valid || o_ready;
  assign pop       = q_nonempty && m_ready;

  // (mag * (alpha << 7)) >> 16 is (mag * alpha) >> 9
  assign scaled    = 18'(q_data.coverage_mag) * 18'(cfg.global_alpha);
  assign mask_calc = q_data.box ? cfg.global_alpha : scaled[16:9];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        m_valid <= 1'b1;
      end else if (m_advance) begin
        m_valid <= 1'b0;
      end
      if (m_advance) begin
        result_valid <= 1'b1;
      end else if (o_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_mask <= mask_calc;
      m_dst  <= q_data.dst_pixel;
      m_box  <= q_data.box;
    end
    if (m_advance) begin
      result <= result_next;
    end
  end

  // Per channel: (s*m + d*(255-m)) >> 8, channels never carry into each other
  always_comb begin
    logic [15:0] lane;
    logic [7:0]  inv;
    inv     = MASK_OPAQUE - m_mask;
    blended = '0;
    for (int c = 0; c < 4; c++) begin
      lane = 16'(cfg.source_color[c*8 +: 8]) * 16'(m_mask)
           + 16'(m_dst[c*8 +: 8]) * 16'(inv);
      blended[c*8 +: 8] = lane[15:8];
    end
  end

  always_comb begin
    result_next.mask_value = m_mask;
    if (m_mask == MASK_NONE) begin
      result_next.out_pixel    = m_dst;
      result_next.write_enable = 1'b0;
    end else if (m_box && m_mask == MASK_OPAQUE) begin
      result_next.out_pixel    = cfg.source_color;
      result_next.write_enable = 1'b1;
    end else begin
      result_next.out_pixel    = blended;
      result_next.write_enable = 1'b1;
    end
  end

endmodule

// ===== design/cmb_checker.sv =====
// ----------------------------------------------------------------------------
// cmb_checker
// Port-level checks for the coverage accumulate / mask / blend unit.
// ----------------------------------------------------------------------------
module cmb_checker
  import cmb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result,
  input logic      pready
);

  // A stalled result holds until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // Write enable is set exactly when the mask is nonzero
  a_write_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.write_enable == (result.mask_value != MASK_NONE)))
    else $error("write enable disagrees with mask");

  // Nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind coverage_accumulate_mask_blend_unit cmb_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .pready       (pready)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the coverage accumulate / mask / blend unit.
// ----------------------------------------------------------------------------
// A directed list of pixels and register writes runs first. It covers zero
// mask, opaque box fill, full analytic mask, the most negative masked value,
// even-odd and empty fill rules, and coverage held across box mode. Random
// phases follow, each with its own register setting. Each phase streams
// rows of pixels with small coverage deltas and some noise. Both channels
// idle and stall in random bursts, except in the last phase. Every result is
// compared against an in-bench model of the pixel pipeline.
// ----------------------------------------------------------------------------
module tb;
  import cmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;

  typedef enum {STEP_PIXEL, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    reg_idx_t    sel;
    logic [31:0] wdata;
    in_item_t    px;
    bit          known;
    out_item_t   typed;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  in_item_t    pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow registers and coverage sum of the model
  logic        mode_q  = 1'b1;
  logic [31:0] color_q = '0;
  logic [7:0]  alpha_q = 8'hFF;
  logic [31:0] rule_q  = '1;
  logic [31:0] cov_sum = ROW_START_COVERAGE;

  out_item_t   due_pixels[$];
  step_t       dir_steps[$];
  bit          row_known = 1'b0;
  out_item_t   row_typed = '0;
  out_item_t   want;
  out_item_t   got_pred;
  bit          calm_tail = 1'b0;
  bit          stall_now = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;

  coverage_accumulate_mask_blend_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Expected result of one pixel; advances the coverage sum in analytic mode
  function automatic out_item_t composite_pixel(in_item_t px);
    logic [31:0] shifted;
    logic [31:0] t;
    logic [31:0] mag;
    logic [31:0] prod;
    logic [15:0] sum;
    logic [7:0]  m;
    out_item_t   r;
    if (mode_q) begin
      cov_sum = (px.row_start ? ROW_START_COVERAGE : cov_sum) + px.cell_delta;
      shifted = $signed(cov_sum) >>> 8;
      t = (shifted & rule_q) - 32'd512;
      mag = t[31] ? -t : t;
      if (mag > 32'd512) mag = 32'd512;
      prod = mag * {17'd0, alpha_q, 7'd0};
      m = prod[23:16];
    end else begin
      m = alpha_q;
    end
    r.mask_value = m;
    r.write_enable = (m != MASK_NONE);
    if (m == MASK_NONE) begin
      r.out_pixel = px.dst_pixel;
    end else if (!mode_q && m == MASK_OPAQUE) begin
      r.out_pixel = color_q;
    end else begin
      for (int ch = 0; ch < 4; ch++) begin
        sum = color_q[8*ch +: 8] * m + px.dst_pixel[8*ch +: 8] * (8'd255 - m);
        r.out_pixel[8*ch +: 8] = sum[15:8];
      end
    end
    return r;
  endfunction

  function automatic void add_pixel_row(logic [31:0] delta, logic [31:0] dst, bit row,
                                        bit known = 1'b0, out_item_t typed = '0);
    step_t s;
    s.kind = STEP_PIXEL;
    s.sel = REG_FILL_MODE;
    s.wdata = '0;
    s.px = '{cell_delta: delta, dst_pixel: dst, row_start: row};
    s.known = known;
    s.typed = typed;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_reg_row(reg_idx_t sel, logic [31:0] val);
    step_t s;
    s.kind = STEP_REG;
    s.sel = sel;
    s.wdata = val;
    s.px = '0;
    s.known = 1'b0;
    s.typed = '0;
    dir_steps.push_back(s);
  endfunction

  // Check results and predict accepted pixels on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (due_pixels.size() == 0) begin
          $error("result with no pixel pending: out_pixel %h", result.out_pixel);
          mismatches++;
        end else begin
          want = due_pixels.pop_front();
          if (result.out_pixel !== want.out_pixel) begin
            $error("out_pixel expected %h got %h", want.out_pixel, result.out_pixel);
            mismatches++;
          end
          if (result.write_enable !== want.write_enable) begin
            $error("write_enable expected %b got %b", want.write_enable,
                   result.write_enable);
            mismatches++;
          end
          if (result.mask_value !== want.mask_value) begin
            $error("mask_value expected %0d got %0d", want.mask_value, result.mask_value);
            mismatches++;
          end
        end
      end
      if (pixel_valid && !pixel_stall) begin
        got_pred = composite_pixel(pixel);
        due_pixels.push_back(row_known ? row_typed : got_pred);
      end
    end
  end

  // Count cycles with no transfer on any port
  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: alternate stall bursts and free stretches
  always @(negedge clk) begin
    if (calm_tail) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_now = ($urandom_range(0, 2) == 0);
        stall_left = stall_now ? $urandom_range(1, 8) : $urandom_range(1, 20);
      end
      stall_left--;
      result_stall <= stall_now;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t sel, input logic [31:0] val);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_FILL_MODE:      mode_q = val[0];
      REG_SOURCE_COLOR:   color_q = val;
      REG_GLOBAL_ALPHA:   alpha_q = val[7:0];
      REG_FILL_RULE_MASK: rule_q = val;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input in_item_t px, input bit known, input out_item_t typed);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        pixel_valid <= 1'b0;
        pixel <= {$urandom(), $urandom(), 1'b1};
      end
    end
    @(negedge clk);
    row_known = known;
    row_typed = typed;
    pixel_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (pixel_stall);
  endtask

  initial begin
    in_item_t    px;
    logic [31:0] color;
    logic [7:0]  alpha;
    logic [31:0] rule;
    int          col;
    int          row_len;

    // Reset state: coverage sits at the row start value, so the mask is zero
    add_pixel_row(32'd0, 32'h1234_5678, 1'b1, 1'b1,
                  '{out_pixel: 32'h1234_5678, write_enable: 1'b0, mask_value: MASK_NONE});
    add_pixel_row(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                  '{out_pixel: 32'hFFFF_FFFF, write_enable: 1'b0, mask_value: MASK_NONE});
    add_reg_row(REG_SOURCE_COLOR, 32'hFFFF_FFFF);
    add_pixel_row(32'h0002_0000, 32'h0000_0000, 1'b0);
    add_pixel_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_pixel_row(32'h8000_0000, 32'h8080_8080, 1'b0);
    add_pixel_row(-32'sd131072, 32'h0000_0000, 1'b1);
    add_pixel_row(32'h0000_0100, 32'h5555_AAAA, 1'b1);
    add_pixel_row(32'h0001_0000, 32'h0000_0000, 1'b1);
    add_reg_row(REG_GLOBAL_ALPHA, 32'd0);
    add_pixel_row(32'h0002_0000, 32'hCAFE_F00D, 1'b1, 1'b1,
                  '{out_pixel: 32'hCAFE_F00D, write_enable: 1'b0, mask_value: MASK_NONE});
    add_reg_row(REG_GLOBAL_ALPHA, 32'd1);
    add_pixel_row(-32'sd131072, 32'hFFFF_FFFF, 1'b1);
    add_reg_row(REG_GLOBAL_ALPHA, 32'd255);
    // Masked value minus 512 lands exactly on the most negative 32-bit number
    add_reg_row(REG_FILL_RULE_MASK, 32'h8000_0200);
    add_pixel_row(32'h8000_0000, 32'h0F0F_0F0F, 1'b1);
    add_reg_row(REG_FILL_RULE_MASK, 32'h0000_01FF);
    add_pixel_row(32'h0003_0000, 32'h1111_2222, 1'b1);
    add_reg_row(REG_FILL_RULE_MASK, 32'h0000_0000);
    add_pixel_row(32'h0000_4000, 32'h3333_4444, 1'b0);
    add_reg_row(REG_FILL_RULE_MASK, 32'hFFFF_FFFF);
    add_pixel_row(32'h0000_8000, 32'h7777_8888, 1'b1);
    // Box fill: coverage input ignored and the sum must hold
    add_reg_row(REG_FILL_MODE, 32'd0);
    add_reg_row(REG_SOURCE_COLOR, 32'hA5C3_E10F);
    add_pixel_row(32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
                  '{out_pixel: 32'hA5C3_E10F, write_enable: 1'b1, mask_value: MASK_OPAQUE});
    add_reg_row(REG_GLOBAL_ALPHA, 32'd0);
    add_pixel_row(32'h8000_0000, 32'h2468_ACE0, 1'b1, 1'b1,
                  '{out_pixel: 32'h2468_ACE0, write_enable: 1'b0, mask_value: MASK_NONE});
    add_reg_row(REG_GLOBAL_ALPHA, 32'd128);
    add_pixel_row(32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    add_reg_row(REG_FILL_MODE, 32'd1);
    add_reg_row(REG_GLOBAL_ALPHA, 32'd255);
    add_pixel_row(32'd0, 32'h9ABC_DEF0, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_REG) begin
        write_reg(dir_steps[i].sel, dir_steps[i].wdata);
      end else begin
        send_pixel(dir_steps[i].px, dir_steps[i].known, dir_steps[i].typed);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0:       color = 32'h0000_0000;
        1:       color = 32'hFFFF_FFFF;
        default: color = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       alpha = 8'd0;
        1:       alpha = 8'd255;
        default: alpha = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 4))
        0:       rule = 32'h0000_01FF;
        1:       rule = 32'h0000_0000;
        2:       rule = $urandom();
        default: rule = 32'hFFFF_FFFF;
      endcase
      if (phase == 0) begin
        alpha = 8'd255;
        rule = 32'hFFFF_FFFF;
      end else if (phase == 3) begin
        alpha = 8'd1;
      end
      write_reg(REG_FILL_MODE, (phase % 3 == 2) ? 32'd0 : 32'd1);
      write_reg(REG_SOURCE_COLOR, color);
      write_reg(REG_GLOBAL_ALPHA, {24'd0, alpha});
      write_reg(REG_FILL_RULE_MASK, rule);
      if (phase == PHASES - 1) calm_tail = 1'b1;

      col = 0;
      row_len = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == 20) wait_drained();
        if (col == 0) row_len = $urandom_range(4, 24);
        px.row_start = (col == 0) || ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 19))
          0, 1, 2:    px.cell_delta = 32'sd0;
          3, 4, 5, 6: px.cell_delta = $urandom();
          default:    px.cell_delta = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
        case ($urandom_range(0, 9))
          0:       px.dst_pixel = 32'h0000_0000;
          1:       px.dst_pixel = 32'hFFFF_FFFF;
          default: px.dst_pixel = $urandom();
        endcase
        send_pixel(px, 1'b0, '0);
        col = (col + 1 >= row_len) ? 0 : col + 1;
      end
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
